// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ttr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttr_pkg
// Shared types and constants of the time-triggered task release core.
// ---------------------------------------------------------------------------
package ttr_pkg;

  localparam int TASK_COUNT = 6;
  localparam int SLOT_REGS  = 6;
  localparam int REG_COUNT  = SLOT_REGS + 1;

  localparam int TICK_W     = 16;
  localparam int FIELD_W    = 8;
  localparam int STEP_W     = $clog2(TICK_W);

  localparam int ADDR_W     = $clog2(REG_COUNT * 4);
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam int DATA_W     = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(60000);

  // Register indexes (byte address divided by four).
  localparam logic [REG_IDX_W-1:0] REG_CYCLE_PERIOD   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TASK_SLOT_0    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TASK_SLOT_LAST = REG_IDX_W'(SLOT_REGS);

  // One task slot register: offset in the high byte, interval in the low byte.
  typedef struct packed {
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] interval;
  } slot_t;

  // One classified tick request passed from the front to the back.
  typedef struct packed {
    logic              pulse;
    logic [TICK_W-1:0] tick;
  } q_entry_t;

endpackage

// ----- hw/rtl/ttr_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttr_front
// Accepts tick requests, advances the wrapping tick counter and queues work.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttr_front import ttr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              tick_pulse,
  input  logic [TICK_W-1:0] cycle_period,
  output logic              push_valid,
  input  logic              push_ready,
  output q_entry_t          push_item
);

  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;
  logic [TICK_W:0]   tick_inc;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // The counter wraps when it would reach the period, so it runs 0..period-1.
  always_comb begin
    tick_inc = {1'b0, tick_count} + (TICK_W + 1)'(1);
    if (tick_inc >= {1'b0, cycle_period}) begin
      tick_count_next = '0;
    end else begin
      tick_count_next = tick_inc[TICK_W-1:0];
    end
    push_item.pulse = tick_pulse;
    push_item.tick  = tick_pulse ? tick_count_next : tick_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (in_valid && in_ready && tick_pulse) begin
      tick_count <= tick_count_next;
    end
  end

  `ASSERT_IMPLIES(a_tick_in_range, push_valid && push_ready && push_item.pulse, push_item.tick == '0 || push_item.tick < cycle_period, "advanced tick outside the cycle period")
  `ASSERT_NEXT(a_hold_without_pulse, in_valid && in_ready && !tick_pulse, $stable(tick_count), "counter moved on a request without a pulse")

endmodule

// ----- hw/rtl/ttr_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttr_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttr_queue import ttr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_item,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_item
);

  q_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue fill count exceeds its depth")

endmodule

// ----- hw/rtl/ttr_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttr_back
// Serial remainder lanes, one per task, and the result output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttr_back import ttr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  q_entry_t              pop_item,
  input  slot_t                 slots [TASK_COUNT],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TASK_COUNT-1:0] release_mask,
  output logic [TICK_W-1:0]     tick_value
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t             state;
  logic [STEP_W-1:0]  step;
  logic               item_pulse;
  logic [TICK_W-1:0]  item_tick;
  logic [TICK_W-1:0]  dvd  [TASK_COUNT];
  logic [FIELD_W-1:0] rem  [TASK_COUNT];

  logic [TICK_W-1:0]  dist_load [TASK_COUNT];
  logic [FIELD_W-1:0] rem_next  [TASK_COUNT];
  logic [FIELD_W:0]   partial   [TASK_COUNT];
  logic [TASK_COUNT-1:0] mask_next;
  logic               last_step;
  logic               out_free;
  logic               step_en;

  assign out_free  = !out_valid || out_ready;
  assign last_step = (step == STEP_W'(TICK_W - 1));
  assign step_en   = (state == ST_RUN) && (!last_step || out_free);
  assign pop_ready = (state == ST_IDLE);

  // Each lane takes one dividend bit per cycle, most significant first, unless a full output register stalls it.
  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      if (pop_item.tick >= {{(TICK_W - FIELD_W){1'b0}}, slots[i].offset}) begin
        dist_load[i] = pop_item.tick - {{(TICK_W - FIELD_W){1'b0}}, slots[i].offset};
      end else begin
        dist_load[i] = {{(TICK_W - FIELD_W){1'b0}}, slots[i].offset} - pop_item.tick;
      end
      partial[i] = {rem[i], dvd[i][TICK_W-1]};
      if (partial[i] >= {1'b0, slots[i].interval}) begin
        partial[i] = partial[i] - {1'b0, slots[i].interval};
      end
      rem_next[i]  = partial[i][FIELD_W-1:0];
      mask_next[i] = item_pulse && (slots[i].interval != '0) && (rem_next[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (step_en && last_step) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            item_pulse <= pop_item.pulse;
            item_tick  <= pop_item.tick;
            for (int i = 0; i < TASK_COUNT; i++) begin
              dvd[i] <= dist_load[i];
              rem[i] <= '0;
            end
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_en) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
              rem[i] <= rem_next[i];
              dvd[i] <= {dvd[i][TICK_W-2:0], 1'b0};
            end
            step <= step + STEP_W'(1);
            if (last_step) begin
              release_mask <= mask_next;
              tick_value   <= item_tick;
              state        <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < TASK_COUNT; g++) begin : g_lane_chk
    `ASSERT_IMPLIES(a_rem_bound, state == ST_RUN && slots[g].interval != '0, rem[g] < slots[g].interval, "lane remainder not below its interval")
  end

  `ASSERT_NEXT(a_stall_on_full, state == ST_RUN && last_step && !out_free, state == ST_RUN && last_step, "lane finished into a full output register")
  `ASSERT_NEXT(a_no_pulse_no_mask, state == ST_RUN && last_step && out_free && !item_pulse, out_valid && release_mask == '0, "release raised on a request without a pulse")

endmodule

// ----- hw/rtl/time_triggered_task_release_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// time_triggered_task_release_core
// Cyclic tick counter with per-task interval and offset release masks.
// ---------------------------------------------------------------------------
// Each request on the input channel is one system tick. When tick_pulse is
// set the tick counter advances by one and wraps to zero when it would reach
// cycle_period, so it runs from 0 to cycle_period-1 (a period of zero holds
// it at zero). Every request gives exactly one result: release_mask has bit i
// set when the distance between the counter and task i's offset is a whole
// multiple of its interval, an interval of zero never releases, and a request
// without a pulse returns a zero mask and the unchanged counter. Each request
// occupies the back end until done: taken from the queue, then restoring
// remainder in six task lanes side by side, one dividend bit a cycle unless
// the output register is full. The front end takes requests while the
// two-entry queue has room, so a short burst is absorbed while the back end
// works or waits for the output register to be taken. The user must write
// registers through the APB port only while the block is idle; not enforced.
// ---------------------------------------------------------------------------

module time_triggered_task_release_core import ttr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  // Tick request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  tick_pulse,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TASK_COUNT-1:0] release_mask,
  output logic [TICK_W-1:0]     tick_value
);

  logic [TICK_W-1:0]    cycle_period;
  slot_t                task_slot [SLOT_REGS];
  slot_t                lane_slot [TASK_COUNT];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  logic                 push_valid;
  logic                 push_ready;
  q_entry_t             push_item;
  logic                 pop_valid;
  logic                 pop_ready;
  q_entry_t             pop_item;

  // The port never inserts wait states; the register index is the word address.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_period <= PERIOD_RESET;
      for (int i = 0; i < SLOT_REGS; i++) begin
        task_slot[i] <= '0;
      end
    end else if (reg_wr) begin
      unique case (reg_idx) inside
        REG_CYCLE_PERIOD: begin
          cycle_period <= pwdata[TICK_W-1:0];
        end
        [REG_TASK_SLOT_0:REG_TASK_SLOT_LAST]: begin
          task_slot[reg_idx - REG_TASK_SLOT_0] <= pwdata[TICK_W-1:0];
        end
        default: begin
          // Addresses beyond the register list are ignored.
        end
      endcase
    end
  end

  // Reads return the register contents; addresses beyond the list read zero.
  always_comb begin
    unique case (reg_idx) inside
      REG_CYCLE_PERIOD: begin
        prdata = {{(DATA_W - TICK_W){1'b0}}, cycle_period};
      end
      [REG_TASK_SLOT_0:REG_TASK_SLOT_LAST]: begin
        prdata = {{(DATA_W - TICK_W){1'b0}}, task_slot[reg_idx - REG_TASK_SLOT_0]};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // The first TASK_COUNT slots, here all of them, feed the remainder lanes.
  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      lane_slot[i] = task_slot[i];
    end
  end

  ttr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick_pulse   (tick_pulse),
    .cycle_period (cycle_period),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  ttr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ttr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .slots        (lane_slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .release_mask (release_mask),
    .tick_value   (tick_value)
  );

endmodule

// ----- sim/time_triggered_task_release_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// time_triggered_task_release_core_test
// Self-checking testbench for the time-triggered task release core.
// ---------------------------------------------------------------------------
// Tick requests are fed from a queue into a valid/ready driver, and every
// accepted request is run through a request-level scheduler model which keeps
// its own copy of the tick counter, the cycle period and the six task slots.
// A monitor compares each result against the oldest predicted release mask
// and tick value. The run opens with a short directed sequence covering the
// extremes of the period and the slots, then carries on with randomly
// configured phases, with random gaps and stalls on both channels and one
// long stall of the result channel that backs the core up into its input.
// ---------------------------------------------------------------------------

module time_triggered_task_release_core_test;
  import ttr_pkg::*;

  // Settling time before touching the registers or ending the run.
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_TICKS   = 72;

  // An index past the end of the register map; writes there are ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(REG_COUNT);

  // One predicted result of the core.
  typedef struct packed {
    logic [TASK_COUNT-1:0] mask;
    logic [TICK_W-1:0]     tick;
  } release_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  tick_pulse = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TASK_COUNT-1:0] release_mask;
  logic [TICK_W-1:0]     tick_value;

  // Requests waiting to be driven, and the results the core owes us.
  bit       tick_requests[$];
  release_t expected_releases[$];

  // Scheduler model state and its copy of the registers.
  logic [TICK_W-1:0] model_tick;
  logic [TICK_W-1:0] model_period;
  slot_t             model_slot[SLOT_REGS];

  int  ticks_queued = 0;
  int  ticks_accepted = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  req_taken = 1'b0;
  bit  src_gaps_on = 1'b1;
  bit  sink_stalls_on = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  long_hold_left = 0;
  int  src_gap = 0;
  int  sink_stall = 0;

  time_triggered_task_release_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick_pulse   (tick_pulse),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .release_mask (release_mask),
    .tick_value   (tick_value)
  );

  always #5 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(0, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Advance the model by one request and work out the result it owes.
  // A task is due when the distance between the counter and its offset,
  // taken either way round, is a whole multiple of its interval; an interval
  // of zero never releases. Without a pulse the counter holds and the mask
  // stays clear.
  function automatic release_t step_scheduler(input bit pulse);
    release_t    res;
    int unsigned nxt;
    int unsigned diff;
    slot_t       sl;
    res.mask = '0;
    if (pulse) begin
      nxt = int'(model_tick) + 1;
      if (nxt >= int'(model_period)) begin
        nxt = 0;
      end
      model_tick = TICK_W'(nxt);
      for (int i = 0; i < TASK_COUNT; i++) begin
        sl = model_slot[i];
        if (sl.interval != '0) begin
          if (model_tick >= TICK_W'(sl.offset)) begin
            diff = int'(model_tick) - int'(sl.offset);
          end else begin
            diff = int'(sl.offset) - int'(model_tick);
          end
          if (diff % int'(sl.interval) == 0) begin
            res.mask[i] = 1'b1;
          end
        end
      end
    end
    res.tick = model_tick;
    return res;
  endfunction

  // Request driver: a new request is presented only once the previous one
  // has been accepted, after a random pause when gaps are enabled.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tick_pulse <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (tick_requests.size() > 0) begin
        in_valid <= 1'b1;
        tick_pulse <= tick_requests.pop_front();
        src_gap = src_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on demand so the
  // core's queue fills and it pushes back on the request channel.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      sink_stall = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    release_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      req_taken = !rst && in_valid && in_ready;
      if (req_taken) begin
        expected_releases.push_back(step_scheduler(tick_pulse));
        ticks_accepted++;
      end
      if (!rst && out_valid && out_ready) begin
        if (expected_releases.size() == 0) begin
          $error("unexpected result: release_mask %0h, tick_value %0d",
                 release_mask, tick_value);
          fail_count++;
        end else begin
          exp_res = expected_releases.pop_front();
          if (release_mask !== exp_res.mask) begin
            $error("release_mask: expected %0h, got %0h", exp_res.mask, release_mask);
            fail_count++;
          end
          if (tick_value !== exp_res.tick) begin
            $error("tick_value: expected %0d, got %0d", exp_res.tick, tick_value);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic offer_tick(input bit pulse);
    tick_requests.push_back(pulse);
    ticks_queued++;
  endtask

  // Waits until every queued request has been accepted and answered, then
  // gives the core time to settle before the registers are touched.
  task automatic wait_idle();
    while (ticks_accepted != ticks_queued || expected_releases.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the data at the edge that
  // ends the access cycle.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_CYCLE_PERIOD) begin
      model_period = data[TICK_W-1:0];
    end else if (idx >= REG_TASK_SLOT_0 && idx <= REG_TASK_SLOT_LAST) begin
      model_slot[idx - REG_TASK_SLOT_0] = data[TICK_W-1:0];
    end
  endtask

  task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx);
    logic [TICK_W-1:0] want;
    if (idx == REG_CYCLE_PERIOD) begin
      want = model_period;
    end else begin
      want = model_slot[idx - REG_TASK_SLOT_0];
    end
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[TICK_W-1:0] !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata[TICK_W-1:0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    slot_t             sv;
    logic [TICK_W-1:0] period;
    model_tick = '0;
    model_period = PERIOD_RESET;
    for (int i = 0; i < SLOT_REGS; i++) begin
      model_slot[i] = '0;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values of every register.
    for (int i = 0; i < REG_COUNT; i++) begin
      apb_read_check(REG_IDX_W'(i));
    end

    // Reset configuration: every interval is zero, so nothing is released
    // while the counter climbs.
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    wait_idle();

    // Short period with a mix of slots: interval one releases on every tick,
    // interval zero never, the widest interval and offset, and offsets above
    // the counter so the distance is taken the other way round. A write past
    // the end of the register map must leave everything alone.
    apb_write(REG_CYCLE_PERIOD, 32'd6);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(0), 32'h0000_0001);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(1), 32'h0000_0302);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(2), 32'h0000_FF00);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(3), 32'h0000_FFFF);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(4), 32'h0000_0503);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(5), 32'h0000_0104);
    apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    for (int i = 0; i < REG_COUNT; i++) begin
      apb_read_check(REG_IDX_W'(i));
    end
    // Runs through the wrap at six, with one request carrying no pulse.
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    wait_idle();

    // Period lowered below the current count, with every task due on every
    // tick so the mask is full.
    apb_write(REG_CYCLE_PERIOD, 32'd2);
    for (int i = 0; i < SLOT_REGS; i++) begin
      apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(i), 32'h0000_0001);
    end
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    wait_idle();

    // A period of one and a period of zero both pin the counter at zero.
    apb_write(REG_CYCLE_PERIOD, 32'd1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    wait_idle();
    apb_write(REG_CYCLE_PERIOD, 32'd0);
    offer_tick(1'b1);
    offer_tick(1'b0);
    offer_tick(1'b1);
    wait_idle();

    // Largest period, largest offsets.
    apb_write(REG_CYCLE_PERIOD, 32'hFFFF_FFFF);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(0), 32'h0000_FF01);
    apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(1), 32'h0000_FF02);
    apb_read_check(REG_CYCLE_PERIOD);
    repeat (4) offer_tick(1'b1);
    wait_idle();

    // Random phases: a fresh configuration each time, then a run of ticks.
    // Most periods are short so the counter wraps often and the offsets sit
    // on both sides of it; now and then a phase runs without any gaps.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      src_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: period = '0;
        1: period = TICK_W'(1);
        2: period = '1;
        3: period = TICK_W'($urandom_range(1, 65535));
        default: period = TICK_W'($urandom_range(2, 120));
      endcase
      apb_write(REG_CYCLE_PERIOD, {16'($urandom), period});
      for (int slot_idx = 0; slot_idx < SLOT_REGS; slot_idx++) begin
        case ($urandom_range(0, 7))
          0: sv.interval = '0;
          1: sv.interval = '1;
          2, 3: sv.interval = FIELD_W'($urandom_range(1, 255));
          default: sv.interval = FIELD_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 3))
          0: sv.offset = '0;
          1: sv.offset = '1;
          2: sv.offset = FIELD_W'($urandom_range(0, 255));
          default: sv.offset = FIELD_W'($urandom_range(0, 20));
        endcase
        apb_write(REG_TASK_SLOT_0 + REG_IDX_W'(slot_idx), {16'($urandom), sv});
      end
      if ($urandom_range(0, 2) == 0) begin
        apb_write(REG_UNMAPPED, $urandom);
      end
      apb_read_check(REG_CYCLE_PERIOD);
      apb_read_check(REG_TASK_SLOT_0 + REG_IDX_W'($urandom_range(0, SLOT_REGS - 1)));
      for (int n = 0; n < PHASE_TICKS; n++) begin
        offer_tick($urandom_range(0, 19) != 0);
      end
      // Once, stall the result channel for a long stretch while requests
      // keep coming, so the core's queue fills and it drops in_ready.
      if (ph == 0) begin
        long_hold_req = 1'b1;
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
